/* design/priority_label_match_lookup_top_macros.svh */
// Assertion macros for the label-match lookup block.
// No dependencies.
`ifndef PRIORITY_LABEL_MATCH_LOOKUP_TOP_MACROS_SVH
`define PRIORITY_LABEL_MATCH_LOOKUP_TOP_MACROS_SVH
`define PLM_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define PLM_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

/* design/plm_pkg.sv */
// Shared types and constants for the label-match lookup block.
// No dependencies.
package plm_pkg;
    localparam int RadiusEntriesDef = 256;
    localparam int ChargeEntriesDef = 256;
    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_RADIUS = 2'd1;
    localparam logic [1:0] ACT_CHARGE = 2'd2;
    localparam logic [1:0] ACT_QUERY  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE, ST_EXEC, ST_SCAN, ST_DRAIN, ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic scan_start;
        logic scan_step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
    } t_stat;

    // Clear every byte after the first zero byte.
    function automatic logic [47:0] norm48(input logic [47:0] v);
        logic [47:0] r;
        logic        z;
        r = '0;
        z = 1'b0;
        for (int i = 5; i >= 0; i--) begin
            if (v[i*8 +: 8] == 8'd0) z = 1'b1;
            if (!z) r[i*8 +: 8] = v[i*8 +: 8];
        end
        return r;
    endfunction

    function automatic logic [23:0] norm24(input logic [23:0] v);
        logic [23:0] r;
        logic        z;
        r = '0;
        z = 1'b0;
        for (int i = 2; i >= 0; i--) begin
            if (v[i*8 +: 8] == 8'd0) z = 1'b1;
            if (!z) r[i*8 +: 8] = v[i*8 +: 8];
        end
        return r;
    endfunction

    // Entry label (normalized) is prefix of atom name.
    function automatic logic is_prefix(input logic [47:0] a, input logic [47:0] e);
        logic ok;
        ok = 1'b1;
        for (int i = 5; i >= 0; i--) begin
            if (e[i*8 +: 8] != 8'd0 && e[i*8 +: 8] != a[i*8 +: 8]) ok = 1'b0;
        end
        return ok;
    endfunction

    function automatic logic [3:0] charge_lev(input logic cm, input logic nm,
                                              input logic rm);
        logic [3:0] l;
        if (cm && nm && rm) l = 4'd8;
        else if (nm && rm) l = 4'd7;
        else if (cm && rm) l = 4'd6;
        else if (rm) l = 4'd5;
        else if (cm && nm) l = 4'd4;
        else if (nm) l = 4'd3;
        else if (cm) l = 4'd2;
        else l = 4'd1;
        return l;
    endfunction
endpackage

/* design/priority_label_match_lookup_top.sv */
// Throughput: one item at a time; a query walks both tables side by side, one
// entry per cycle through the registered table read port.
// Reset: synchronous active-low i_rst_n clears both counts and the controller.
// Top level of the label-match lookup block; depends on plm_pkg, plm_ctrl, plm_dp.
module priority_label_match_lookup_top #(
    parameter int RADIUS_ENTRIES = plm_pkg::RadiusEntriesDef,
    parameter int CHARGE_ENTRIES = plm_pkg::ChargeEntriesDef
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // action[1:0] atom_label[49:2] residue_label[73:50] residue_number[88:74]
    // chain[96:89] entry_value[128:97] pad
    input  logic [135:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[0] radius_out[32:1] radius_level[34:33] charge_out[66:35]
    // charge_level[70:67] pad
    output logic [71:0]  m_axis_tdata
);
    plm_pkg::t_cmd  cmd;
    plm_pkg::t_stat stat;
    logic [71:0]    result;

    plm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_action(s_axis_tdata[1:0]),
        .i_out_ready(m_axis_tready), .i_stat(stat),
        .o_in_ready(s_axis_tready), .o_out_valid(m_axis_tvalid), .o_cmd(cmd)
    );

    plm_dp #(.RADIUS_ENTRIES(RADIUS_ENTRIES), .CHARGE_ENTRIES(CHARGE_ENTRIES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_action(s_axis_tdata[1:0]), .i_atom_label(s_axis_tdata[49:2]),
        .i_residue_label(s_axis_tdata[73:50]), .i_residue_number(s_axis_tdata[88:74]),
        .i_chain(s_axis_tdata[96:89]), .i_entry_value(s_axis_tdata[128:97]),
        .o_stat(stat), .o_result(result)
    );

    assign m_axis_tdata = result;
endmodule

/* design/plm_ctrl.sv */
// Controller state machine for the label-match lookup block.
// Depends on plm_pkg.
`include "priority_label_match_lookup_top_macros.svh"
module plm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [1:0]      i_action,
    input  logic            i_out_ready,
    input  plm_pkg::t_stat  i_stat,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output plm_pkg::t_cmd   o_cmd
);
    plm_pkg::t_state r_state, n_state;
    logic            r_oval, n_oval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plm_pkg::ST_IDLE;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_oval  <= n_oval;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            plm_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_action == plm_pkg::ACT_QUERY) n_state = plm_pkg::ST_SCAN;
                    else n_state = plm_pkg::ST_EXEC;
                end
            end
            plm_pkg::ST_EXEC: n_state = plm_pkg::ST_OUT;
            plm_pkg::ST_SCAN: begin
                if (i_stat.scan_done) n_state = plm_pkg::ST_DRAIN;
            end
            plm_pkg::ST_DRAIN: n_state = plm_pkg::ST_OUT;
            plm_pkg::ST_OUT: begin
                if (!r_oval || i_out_ready) n_state = plm_pkg::ST_IDLE;
            end
            default: n_state = plm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_in_ready       = 1'b0;
        o_cmd.load       = 1'b0;
        case (r_state)
            plm_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
                o_cmd.scan_start = i_in_valid;
            end
            plm_pkg::ST_EXEC: o_cmd.exec = 1'b1;
            plm_pkg::ST_SCAN: o_cmd.scan_step = 1'b1;
            plm_pkg::ST_DRAIN: o_cmd.scan_step = 1'b1;
            plm_pkg::ST_OUT: o_cmd.emit = !r_oval || i_out_ready;
            default: o_in_ready = 1'b0;
        endcase
    end

    always_comb begin
        n_oval = r_oval;
        if (r_oval && i_out_ready) n_oval = 1'b0;
        if (o_cmd.emit) n_oval = 1'b1;
    end

    assign o_out_valid = r_oval;

    `PLM_ASSERT_IMPL(a_ready_idle, i_clk, i_rst_n, o_in_ready, r_state == plm_pkg::ST_IDLE)
    `PLM_ASSERT_NEXT(a_emit_valid, i_clk, i_rst_n, o_cmd.emit, r_oval)
    `PLM_ASSERT_NEXT(a_drain_out, i_clk, i_rst_n, r_state == plm_pkg::ST_DRAIN, r_state == plm_pkg::ST_OUT)
endmodule

/* design/plm_dp.sv */
// Datapath of the label-match lookup block: tables, counts, scan and match.
// Depends on plm_pkg.
`include "priority_label_match_lookup_top_macros.svh"
module plm_dp #(
    parameter int RADIUS_ENTRIES = plm_pkg::RadiusEntriesDef,
    parameter int CHARGE_ENTRIES = plm_pkg::ChargeEntriesDef
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  plm_pkg::t_cmd   i_cmd,
    input  logic [1:0]      i_action,
    input  logic [47:0]     i_atom_label,
    input  logic [23:0]     i_residue_label,
    input  logic [14:0]     i_residue_number,
    input  logic [7:0]      i_chain,
    input  logic [31:0]     i_entry_value,
    output plm_pkg::t_stat  o_stat,
    output logic [71:0]     o_result
);
    localparam int RAW = (RADIUS_ENTRIES > 1) ? $clog2(RADIUS_ENTRIES) : 1;
    localparam int CAW = (CHARGE_ENTRIES > 1) ? $clog2(CHARGE_ENTRIES) : 1;
    localparam int RCW = $clog2(RADIUS_ENTRIES + 1);
    localparam int CCW = $clog2(CHARGE_ENTRIES + 1);
    localparam int SW  = (RCW > CCW) ? RCW : CCW;

    logic [103:0] r_rmem [RADIUS_ENTRIES];
    logic [126:0] r_cmem [CHARGE_ENTRIES];
    logic [RCW-1:0] r_rcnt;
    logic [CCW-1:0] r_ccnt;
    logic [1:0]   r_act;
    logic [47:0]  r_atom;
    logic [23:0]  r_res;
    logic [14:0]  r_num;
    logic [7:0]   r_ch;
    logic [31:0]  r_val;
    logic [SW-1:0] r_idx;
    logic         r_rv, r_cv;
    logic [103:0] r_rrd;
    logic [126:0] r_crd;
    logic         r_rstop, r_cstop;
    logic [31:0]  r_rout, r_cout;
    logic [1:0]   r_rlev;
    logic [3:0]   r_clev;
    logic         r_status;
    logic [71:0]  r_result;

    logic [47:0] ea, ca;
    logic [23:0] er, cr;
    logic [1:0]  rl;
    logic [3:0]  cl;
    logic        rstop_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rcnt <= '0;
            r_ccnt <= '0;
        end else if (i_cmd.exec) begin
            case (r_act)
                plm_pkg::ACT_CLEAR: begin
                    r_rcnt <= '0;
                    r_ccnt <= '0;
                end
                plm_pkg::ACT_RADIUS: begin
                    if (r_rcnt < RCW'(RADIUS_ENTRIES)) r_rcnt <= r_rcnt + 1'b1;
                end
                plm_pkg::ACT_CHARGE: begin
                    if (r_ccnt < CCW'(CHARGE_ENTRIES)) r_ccnt <= r_ccnt + 1'b1;
                end
                default: r_rcnt <= r_rcnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && r_act == plm_pkg::ACT_RADIUS && r_rcnt < RCW'(RADIUS_ENTRIES))
            r_rmem[r_rcnt[RAW-1:0]] <= {r_val, r_res, r_atom};
        if (i_cmd.exec && r_act == plm_pkg::ACT_CHARGE && r_ccnt < CCW'(CHARGE_ENTRIES))
            r_cmem[r_ccnt[CAW-1:0]] <= {r_val, r_ch, r_num, r_res, r_atom};
        r_rrd <= r_rmem[r_idx[RAW-1:0]];
        r_crd <= r_cmem[r_idx[CAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act  <= i_action;
            r_atom <= plm_pkg::norm48(i_atom_label);
            r_res  <= plm_pkg::norm24(i_residue_label);
            r_num  <= i_residue_number;
            r_ch   <= i_chain;
            r_val  <= i_entry_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_rv  <= 1'b0;
            r_cv  <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_idx <= '0;
            r_rv  <= 1'b0;
            r_cv  <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_idx <= r_idx + 1'b1;
            r_rv  <= SW'(r_idx) < SW'(r_rcnt);
            r_cv  <= SW'(r_idx) < SW'(r_ccnt);
        end
    end

    assign o_stat.scan_done = (r_idx >= SW'(r_rcnt)) && (r_idx >= SW'(r_ccnt));

    assign ea = r_rrd[47:0];
    assign er = r_rrd[71:48];
    assign ca = r_crd[47:0];
    assign cr = r_crd[71:48];

    always_comb begin
        rl = 2'd0;
        rstop_hit = 1'b0;
        if (ea == r_atom && er == r_res) begin
            rl = 2'd3;
            rstop_hit = 1'b1;
        end else if (er == 24'd0 && plm_pkg::is_prefix(r_atom, ea)) begin
            rl = 2'd2;
        end
        cl = 4'd0;
        if (ca == r_atom)
            cl = plm_pkg::charge_lev(r_crd[94:87] == r_ch, r_crd[86:72] == r_num,
                                     cr == r_res);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_rstop <= 1'b0;
            r_cstop <= 1'b0;
            r_rout  <= '0;
            r_cout  <= '0;
            r_rlev  <= '0;
            r_clev  <= '0;
        end else if (i_cmd.scan_step) begin
            if (r_rv && !r_rstop && rl > r_rlev) begin
                r_rlev <= rl;
                r_rout <= r_rrd[103:72];
            end
            if (r_rv && rstop_hit) r_rstop <= 1'b1;
            if (r_cv && !r_cstop && cl > r_clev) begin
                r_clev <= cl;
                r_cout <= r_crd[126:95];
            end
            if (r_cv && cl == 4'd8) r_cstop <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= (r_act == plm_pkg::ACT_RADIUS && r_rcnt >= RCW'(RADIUS_ENTRIES))
                     || (r_act == plm_pkg::ACT_CHARGE && r_ccnt >= CCW'(CHARGE_ENTRIES));
        end else if (i_cmd.scan_start) begin
            r_status <= 1'b0;
        end
        if (i_cmd.emit) begin
            if (r_act == plm_pkg::ACT_QUERY)
                r_result <= {1'b0, r_clev, r_cout, r_rlev, r_rout, 1'b0};
            else
                r_result <= {1'b0, 4'd0, 32'd0, 2'd0, 32'd0, r_status};
        end
    end

    assign o_result = r_result;

    `PLM_ASSERT_IMPL(a_rcnt_max, i_clk, i_rst_n, 1'b1, r_rcnt <= RCW'(RADIUS_ENTRIES))
    `PLM_ASSERT_IMPL(a_ccnt_max, i_clk, i_rst_n, 1'b1, r_ccnt <= CCW'(CHARGE_ENTRIES))
    `PLM_ASSERT_NEXT(a_rstop, i_clk, i_rst_n, r_rstop && i_cmd.scan_step, r_rlev == 2'd3)
endmodule
